[rtl/dqsc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the DNS question-name suffix classifier.
// No dependencies; the top level, walker and matcher refer to it by scoped names.
package dqsc_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int NAME_LIMIT   = 256;
    localparam int TAIL_DEPTH   = 14;
    localparam int TEXT_LEN_W   = 9;
    localparam int TAIL_W       = 8 * TAIL_DEPTH;

    localparam logic [79:0]  SUFFIX_SHORT = {8'h2e, "tidal", 8'h2e, "com"};
    localparam logic [111:0] SUFFIX_LONG  = {8'h2e, "tidalhifi", 8'h2e, "com"};

    typedef enum logic [1:0] {
        VERDICT_FORWARD = 2'd0,
        VERDICT_LOCAL   = 2'd1,
        VERDICT_DROP    = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [TAIL_W-1:0]     tail;
        logic [TEXT_LEN_W-1:0] text_len;
    } t_name;

    typedef struct packed {
        logic short_pkt;
        logic classify;
        logic in_header;
    } t_walk_stat;

endpackage

[rtl/dqsc_in_if.sv]
`timescale 1ns / 1ps
// Packet byte channel: valid/ready handshake with one byte and a last mark.
// Standalone; used by the classifier top level.
interface dqsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       is_final;

    modport source (output valid, output packet_byte, output is_final, input ready);
    modport sink   (input valid, input packet_byte, input is_final, output ready);
endinterface

[rtl/dqsc_out_if.sv]
`timescale 1ns / 1ps
// Verdict channel: valid/ready handshake carrying one 2-bit verdict per packet.
// Standalone; used by the classifier top level.
interface dqsc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

[rtl/dns_qname_suffix_classifier.sv]
`timescale 1ns / 1ps
// DNS question-name suffix classifier top level: input register, walker and
// matcher, verdict register. Depends on dqsc_pkg, dqsc_in_if, dqsc_out_if.
// The verdict is registered: the last beat passes the input register, then the verdict register.
// Throughput: one beat per cycle, unless a last beat waits on an undelivered verdict.
// Reset (synchronous, active low) empties both registers and returns to header.
module dns_qname_suffix_classifier (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dqsc_in_if.sink          i_pkt,
    dqsc_out_if.source       o_res
);

    logic                  r_vld;
    logic [7:0]            r_byte;
    logic                  r_fin;
    logic                  r_out_valid, n_out_valid;
    dqsc_pkg::t_verdict    r_verdict, n_verdict;
    logic                  adv;
    logic                  in_acc;
    logic                  hit;
    dqsc_pkg::t_name       name;
    dqsc_pkg::t_walk_stat  stat;

    assign adv          = r_vld && (!r_fin || !r_out_valid || o_res.ready);
    assign i_pkt.ready  = !r_vld || adv;
    assign in_acc       = i_pkt.valid && i_pkt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (in_acc) begin
            r_vld <= 1'b1;
        end else if (adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_pkt.packet_byte;
            r_fin  <= i_pkt.is_final;
        end
    end

    dqsc_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_byte),
        .i_fin   (r_fin),
        .o_name  (name),
        .o_stat  (stat)
    );

    dqsc_match u_match (
        .i_name (name),
        .o_hit  (hit)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_verdict   = r_verdict;
        if (adv && r_fin) begin
            n_out_valid = 1'b1;
            priority if (stat.short_pkt) begin
                n_verdict = dqsc_pkg::VERDICT_DROP;
            end else if (stat.classify && hit) begin
                n_verdict = dqsc_pkg::VERDICT_LOCAL;
            end else begin
                n_verdict = dqsc_pkg::VERDICT_FORWARD;
            end
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.verdict = r_verdict;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_fin) |-> (!r_out_valid || o_res.ready))
        else $error("verdict register overwritten before delivery");

    a_back_to_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_fin) |=> stat.in_header)
        else $error("walker not back in header after last beat");

    a_legal_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.verdict != 2'd3))
        else $error("undefined verdict code presented");

endmodule

[rtl/dqsc_walker.sv]
`timescale 1ns / 1ps
// Header skip and label walker: tracks parse phase, lengths and the text tail.
// Depends on dqsc_pkg.
module dqsc_walker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic [7:0]              i_byte,
    input  logic                    i_fin,
    output dqsc_pkg::t_name         o_name,
    output dqsc_pkg::t_walk_stat    o_stat
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_LABEL  = 3'd2;
    localparam logic [2:0] PH_DONE   = 3'd3;
    localparam logic [2:0] PH_REJECT = 3'd4;

    logic [2:0]                          r_phase, n_phase;
    logic [3:0]                          r_hdr_cnt, n_hdr_cnt;
    logic [5:0]                          r_lab_rem, n_lab_rem;
    logic [dqsc_pkg::TEXT_LEN_W-1:0]     r_text_len, n_text_len;
    logic [dqsc_pkg::TAIL_W-1:0]         r_tail, n_tail;
    logic                                push;
    logic [7:0]                          ch;
    logic [dqsc_pkg::TEXT_LEN_W:0]       len_sum;
    logic                                short_pkt;
    logic                                classify;

    assign len_sum = {1'b0, r_text_len} + {2'b00, i_byte} + 10'd1;

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_lab_rem = r_lab_rem;
        push      = 1'b0;
        ch        = 8'h00;
        short_pkt = 1'b0;
        classify  = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                if ({1'b0, r_hdr_cnt} + 5'd1 >= 5'(dqsc_pkg::HEADER_BYTES)) begin
                    n_phase  = PH_LENGTH;
                    classify = 1'b1;
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 4'd1;
                    short_pkt = 1'b1;
                end
            end
            PH_LENGTH: begin
                if (i_byte == 8'h00) begin
                    n_phase  = PH_DONE;
                    classify = 1'b1;
                end else if (i_byte[7:6] != 2'b00 ||
                             len_sum >= 10'(dqsc_pkg::NAME_LIMIT) || i_fin) begin
                    n_phase = PH_REJECT;
                end else begin
                    push      = (r_text_len != '0);
                    ch        = 8'h2e;
                    n_lab_rem = i_byte[5:0];
                    n_phase   = PH_LABEL;
                end
            end
            PH_LABEL: begin
                push      = 1'b1;
                ch        = (i_byte >= 8'h41 && i_byte <= 8'h5a) ? i_byte + 8'd32 : i_byte;
                n_lab_rem = r_lab_rem - 6'd1;
                if (n_lab_rem == 6'd0) begin
                    n_phase  = PH_LENGTH;
                    classify = 1'b1;
                end
            end
            PH_DONE: begin
                classify = 1'b1;
            end
            default: begin
                classify = 1'b0;
            end
        endcase
        n_tail     = push ? {r_tail[dqsc_pkg::TAIL_W-9:0], ch} : r_tail;
        n_text_len = push ? r_text_len + 9'd1 : r_text_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_cnt  <= '0;
            r_lab_rem  <= '0;
            r_text_len <= '0;
        end else if (i_adv) begin
            if (i_fin) begin
                r_phase    <= PH_HEADER;
                r_hdr_cnt  <= '0;
                r_lab_rem  <= '0;
                r_text_len <= '0;
            end else begin
                r_phase    <= n_phase;
                r_hdr_cnt  <= n_hdr_cnt;
                r_lab_rem  <= n_lab_rem;
                r_text_len <= n_text_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tail <= n_tail;
        end
    end

    assign o_name.tail      = n_tail;
    assign o_name.text_len  = n_text_len;
    assign o_stat.short_pkt = short_pkt;
    assign o_stat.classify  = classify;
    assign o_stat.in_header = (r_phase == PH_HEADER);

endmodule

[rtl/dqsc_match.sv]
`timescale 1ns / 1ps
// Suffix comparator: checks the text tail and length against both domains.
// Depends on dqsc_pkg.
module dqsc_match (
    input  dqsc_pkg::t_name i_name,
    output logic            o_hit
);

    logic hit_short_eq, hit_short_sfx, hit_long_eq, hit_long_sfx;

    assign hit_short_eq  = (i_name.text_len == 9'd9) &&
                           (i_name.tail[71:0] == dqsc_pkg::SUFFIX_SHORT[71:0]);
    assign hit_short_sfx = (i_name.text_len > 9'd10) &&
                           (i_name.tail[79:0] == dqsc_pkg::SUFFIX_SHORT);
    assign hit_long_eq   = (i_name.text_len == 9'd13) &&
                           (i_name.tail[103:0] == dqsc_pkg::SUFFIX_LONG[103:0]);
    assign hit_long_sfx  = (i_name.text_len > 9'd14) &&
                           (i_name.tail[111:0] == dqsc_pkg::SUFFIX_LONG);

    assign o_hit = hit_short_eq | hit_short_sfx | hit_long_eq | hit_long_sfx;

endmodule
